[src/tpq_pkg.sv]
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types, sizes and codes for the timestamp priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tpq_pkg;

  // table size and derived widths
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int OP_W   = 2;
  localparam int TIME_W = 16;
  localparam int PROC_W = 4;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  // request opcodes
  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // one stored request
  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [PROC_W-1:0] proc;
  } entry_t;

endpackage

`default_nettype wire

[src/tpq_best.sv]
// ----------------------------------------------------------------------------
// tpq_best
// Shared comparator and best-so-far register used by the table scan.
// ----------------------------------------------------------------------------
`default_nettype none

module tpq_best (
  input  wire                            clk,
  input  wire                            load_en,
  input  wire                            first,
  input  wire tpq_pkg::entry_t           cand,
  input  wire logic [tpq_pkg::IDX_W-1:0] cand_idx,
  output tpq_pkg::entry_t                best,
  output logic [tpq_pkg::IDX_W-1:0]      best_idx
);

  tpq_pkg::entry_t                best_r;
  logic [tpq_pkg::IDX_W-1:0]      best_idx_r;
  logic                           beats;

  // earlier timestamp wins, then lower process id; ties keep the older pick
  assign beats = (cand.stamp < best_r.stamp) ||
                 ((cand.stamp == best_r.stamp) && (cand.proc < best_r.proc));

  // best-so-far update
  always_ff @(posedge clk) begin
    if (load_en && (first || beats)) begin
      best_r     <= cand;
      best_idx_r <= cand_idx;
    end
  end

  assign best     = best_r;
  assign best_idx = best_idx_r;

endmodule

`default_nettype wire

[src/timestamp_priority_queue.sv]
// ----------------------------------------------------------------------------
// timestamp_priority_queue
// Request table of (timestamp, process id) pairs with enqueue, dequeue and
// peek of the earliest request, found by a scan with one shared comparator.
// ----------------------------------------------------------------------------
// Usage:
//   A request enters on in_valid/in_ready with an opcode and, for enqueue,
//   the timestamp and process id. Each request gives exactly one result on
//   out_valid/out_ready: status, winning pair and the occupancy afterwards.
//   The block takes one request at a time; in_ready is high only while the
//   sequencer is idle.
//   Enqueue, unused opcodes and requests on an empty table go straight from
//   idle to the result state. Peek and dequeue scan the N stored entries:
//   the scan reads one table entry per cycle through the single read port,
//   and the comparator takes each entry in the cycle after its read; a
//   dequeue then moves the last entry into the freed slot.
//   Reset empties the table at once (entry count cleared, no clearing pass).
//   If the receiver stalls, the result stays in the output register and a
//   following request waits in the result state until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_priority_queue (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire logic [tpq_pkg::OP_W-1:0]    in_opcode,
  input  wire logic [tpq_pkg::TIME_W-1:0]  in_request_time,
  input  wire logic [tpq_pkg::PROC_W-1:0]  in_request_proc,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [tpq_pkg::STAT_W-1:0]       out_status,
  output logic [tpq_pkg::TIME_W-1:0]       out_winner_time,
  output logic [tpq_pkg::PROC_W-1:0]       out_winner_proc,
  output logic [tpq_pkg::OCC_W-1:0]        out_occupancy
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_MOVE = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [tpq_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [tpq_pkg::CNT_W-1:0]       scan_k_r, scan_k_nxt;
  logic                            cmp_v_r, cmp_v_nxt;
  logic [tpq_pkg::IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic [tpq_pkg::OP_W-1:0]        op_r, op_nxt;
  logic [tpq_pkg::STAT_W-1:0]      res_status_r, res_status_nxt;
  logic                            res_win_r, res_win_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [tpq_pkg::STAT_W-1:0]      out_status_r, out_status_nxt;
  logic [tpq_pkg::TIME_W-1:0]      out_time_r, out_time_nxt;
  logic [tpq_pkg::PROC_W-1:0]      out_proc_r, out_proc_nxt;
  logic [tpq_pkg::OCC_W-1:0]       out_occ_r, out_occ_nxt;

  // table memory, one write and one registered read port
  tpq_pkg::entry_t                 mem [tpq_pkg::QUEUE_DEPTH];
  tpq_pkg::entry_t                 rd_data_r;
  tpq_pkg::entry_t                 wr_data;
  logic                            rd_en, wr_en;
  logic [tpq_pkg::IDX_W-1:0]       rd_addr, wr_addr;

  tpq_pkg::entry_t                 best;
  logic [tpq_pkg::IDX_W-1:0]       best_idx;
  logic [tpq_pkg::CNT_W-1:0]       last;
  logic                            accept;

  assign accept = in_valid && in_ready;
  assign last   = count_r - tpq_pkg::CNT_W'(1);

  // shared comparator
  tpq_best u_best (
    .clk      (clk),
    .load_en  (cmp_v_r),
    .first    (cmp_idx_r == '0),
    .cand     (rd_data_r),
    .cand_idx (cmp_idx_r),
    .best     (best),
    .best_idx (best_idx)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_k_nxt     = scan_k_r;
    cmp_v_nxt      = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    op_nxt         = op_r;
    res_status_nxt = res_status_r;
    res_win_nxt    = res_win_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_time_nxt   = out_time_r;
    out_proc_nxt   = out_proc_r;
    out_occ_nxt    = out_occ_r;
    rd_en          = 1'b0;
    rd_addr        = scan_k_r[tpq_pkg::IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = count_r[tpq_pkg::IDX_W-1:0];
    wr_data        = '{stamp: in_request_time, proc: in_request_proc};
    in_ready       = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt         = in_opcode;
          res_status_nxt = tpq_pkg::ST_OK;
          res_win_nxt    = 1'b0;
          state_nxt      = S_FIN;
          unique case (in_opcode) inside
            tpq_pkg::OP_ENQ: begin
              if (count_r == tpq_pkg::CNT_W'(tpq_pkg::QUEUE_DEPTH)) begin
                res_status_nxt = tpq_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + tpq_pkg::CNT_W'(1);
              end
            end
            tpq_pkg::OP_DEQ, tpq_pkg::OP_PEEK: begin
              if (count_r == '0) begin
                res_status_nxt = tpq_pkg::ST_EMPTY;
              end else begin
                scan_k_nxt = '0;
                state_nxt  = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_k_r < count_r) begin
          // issue the next read, compare it in the next cycle
          rd_en       = 1'b1;
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = scan_k_r[tpq_pkg::IDX_W-1:0];
          scan_k_nxt  = scan_k_r + tpq_pkg::CNT_W'(1);
        end else if (!cmp_v_r) begin
          res_win_nxt = 1'b1;
          if (op_r == tpq_pkg::OP_DEQ) begin
            // fetch the last entry to fill the freed slot
            rd_en     = 1'b1;
            rd_addr   = last[tpq_pkg::IDX_W-1:0];
            state_nxt = S_MOVE;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_MOVE: begin
        wr_en     = 1'b1;
        wr_addr   = best_idx;
        wr_data   = rd_data_r;
        count_nxt = last;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_time_nxt   = res_win_r ? best.stamp : '0;
          out_proc_nxt   = res_win_r ? best.proc : '0;
          out_occ_nxt    = tpq_pkg::OCC_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_k_r     <= scan_k_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    op_r         <= op_nxt;
    res_status_r <= res_status_nxt;
    res_win_r    <= res_win_nxt;
    out_status_r <= out_status_nxt;
    out_time_r   <= out_time_nxt;
    out_proc_r   <= out_proc_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  // table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_winner_time = out_time_r;
  assign out_winner_proc = out_proc_r;
  assign out_occupancy   = out_occ_r;

  // entry count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= tpq_pkg::CNT_W'(tpq_pkg::QUEUE_DEPTH))
    else $error("entry count above table size");

  // scan pointer stays within the stored entries
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_k_r <= count_r))
    else $error("scan pointer beyond entry count");

  // a full report always shows a full table
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == tpq_pkg::ST_FULL) |->
      (out_occ_r == tpq_pkg::OCC_W'(tpq_pkg::QUEUE_DEPTH)))
    else $error("full status with table not full");

  // an empty report always shows an empty table and no winner
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == tpq_pkg::ST_EMPTY) |->
      (out_occ_r == '0 && out_time_r == '0 && out_proc_r == '0))
    else $error("empty status with entries or a winner");

  // the table only changes in count while a request is being worked on
  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> (count_r == $past(count_r)))
    else $error("entry count changed after the request finished");

endmodule

`default_nettype wire

[dv/tpq_checker.sv]
// ----------------------------------------------------------------------------
// tpq_checker
// Watches both channels of the timestamp priority queue, keeps its own copy
// of the request table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tpq_checker (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  input  wire                              in_ready,
  input  wire logic [tpq_pkg::OP_W-1:0]    in_opcode,
  input  wire logic [tpq_pkg::TIME_W-1:0]  in_request_time,
  input  wire logic [tpq_pkg::PROC_W-1:0]  in_request_proc,
  input  wire                              out_valid,
  input  wire                              out_ready,
  input  wire logic [tpq_pkg::STAT_W-1:0]  out_status,
  input  wire logic [tpq_pkg::TIME_W-1:0]  out_winner_time,
  input  wire logic [tpq_pkg::PROC_W-1:0]  out_winner_proc,
  input  wire logic [tpq_pkg::OCC_W-1:0]   out_occupancy,
  output int                               errors,
  output int                               pending,
  output int                               results_seen,
  output int                               full_hits,
  output int                               empty_hits
);

  timeunit 1ns;
  timeprecision 1ps;

  // one predicted result
  typedef struct packed {
    logic [tpq_pkg::STAT_W-1:0] status;
    logic [tpq_pkg::TIME_W-1:0] stamp;
    logic [tpq_pkg::PROC_W-1:0] proc;
    logic [tpq_pkg::OCC_W-1:0]  occ;
  } result_t;

  // shadow of the request table
  logic [tpq_pkg::TIME_W-1:0] table_stamp [tpq_pkg::QUEUE_DEPTH];
  logic [tpq_pkg::PROC_W-1:0] table_proc  [tpq_pkg::QUEUE_DEPTH];
  int                         table_count;

  result_t                    awaited_q [$];
  result_t                    want;

  // apply one request to the shadow table and return its result
  function automatic result_t serve_request(logic [tpq_pkg::OP_W-1:0] op,
                                            logic [tpq_pkg::TIME_W-1:0] stamp,
                                            logic [tpq_pkg::PROC_W-1:0] proc);
    result_t res;
    int      best;
    int      last;
    res        = '0;
    res.status = tpq_pkg::ST_OK;
    case (op) inside
      tpq_pkg::OP_ENQ: begin
        if (table_count >= tpq_pkg::QUEUE_DEPTH) begin
          res.status = tpq_pkg::ST_FULL;
        end else begin
          table_stamp[table_count] = stamp;
          table_proc[table_count]  = proc;
          table_count++;
        end
      end
      tpq_pkg::OP_DEQ, tpq_pkg::OP_PEEK: begin
        if (table_count == 0) begin
          res.status = tpq_pkg::ST_EMPTY;
        end else begin
          // earliest stamp, then lower id, first slot kept on equal pairs
          best = 0;
          for (int i = 1; i < table_count; i++) begin
            if (table_stamp[i] < table_stamp[best] ||
                (table_stamp[i] == table_stamp[best] && table_proc[i] < table_proc[best]))
              best = i;
          end
          res.stamp = table_stamp[best];
          res.proc  = table_proc[best];
          // last entry fills the freed slot
          if (op == tpq_pkg::OP_DEQ) begin
            last              = table_count - 1;
            table_stamp[best] = table_stamp[last];
            table_proc[best]  = table_proc[last];
            table_count       = last;
          end
        end
      end
      default: ;
    endcase
    res.occ = table_count[tpq_pkg::OCC_W-1:0];
    return res;
  endfunction

  // results are matched before new requests, a result never belongs to a
  // request taken at the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      table_count  = 0;
      awaited_q.delete();
      errors       = 0;
      results_seen = 0;
      full_hits    = 0;
      empty_hits   = 0;
    end else begin
      // result channel
      if (out_valid && out_ready) begin
        if (awaited_q.size() == 0) begin
          $error("result with no request outstanding: status %0d time %0h proc %0h occ %0d",
                 out_status, out_winner_time, out_winner_proc, out_occupancy);
          errors++;
        end else begin
          want = awaited_q.pop_front();
          results_seen++;
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
            errors++;
          end
          if (out_winner_time !== want.stamp) begin
            $error("winner_time mismatch: expected %0h, actual %0h",
                   want.stamp, out_winner_time);
            errors++;
          end
          if (out_winner_proc !== want.proc) begin
            $error("winner_proc mismatch: expected %0h, actual %0h",
                   want.proc, out_winner_proc);
            errors++;
          end
          if (out_occupancy !== want.occ) begin
            $error("occupancy mismatch: expected %0d, actual %0d", want.occ, out_occupancy);
            errors++;
          end
        end
      end
      // request channel
      if (in_valid && in_ready) begin
        want = serve_request(in_opcode, in_request_time, in_request_proc);
        if (want.status == tpq_pkg::ST_FULL)  full_hits++;
        if (want.status == tpq_pkg::ST_EMPTY) empty_hits++;
        awaited_q.push_back(want);
      end
    end
    pending = awaited_q.size();
  end

endmodule

`default_nettype wire

[dv/tb_timestamp_priority_queue.sv]
// ----------------------------------------------------------------------------
// tb_timestamp_priority_queue
// Drives directed and random request streams into the timestamp priority
// queue with random idling on both channels; the checker predicts results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_timestamp_priority_queue;

  timeunit 1ns;
  timeprecision 1ps;

  // opcode with no defined operation
  localparam logic [tpq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS  = 1400;
  localparam int PHASE_LEN     = 100;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 600000;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic                         clk             = 1'b0;
  logic                         rst_n           = 1'b0;
  logic                         in_valid        = 1'b0;
  logic                         in_ready;
  logic [tpq_pkg::OP_W-1:0]     in_opcode       = tpq_pkg::OP_ENQ;
  logic [tpq_pkg::TIME_W-1:0]   in_request_time = '0;
  logic [tpq_pkg::PROC_W-1:0]   in_request_proc = '0;
  logic                         out_valid;
  logic                         out_ready       = 1'b0;
  logic [tpq_pkg::STAT_W-1:0]   out_status;
  logic [tpq_pkg::TIME_W-1:0]   out_winner_time;
  logic [tpq_pkg::PROC_W-1:0]   out_winner_proc;
  logic [tpq_pkg::OCC_W-1:0]    out_occupancy;

  int                           errors;
  int                           pending;
  int                           results_seen;
  int                           full_hits;
  int                           empty_hits;
  int                           op_count [4];
  int                           cycle_count;
  bit                           no_idle;

  timestamp_priority_queue dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_request_time (in_request_time),
    .in_request_proc (in_request_proc),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_winner_time (out_winner_time),
    .out_winner_proc (out_winner_proc),
    .out_occupancy   (out_occupancy)
  );

  tpq_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_request_time (in_request_time),
    .in_request_proc (in_request_proc),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_winner_time (out_winner_time),
    .out_winner_proc (out_winner_proc),
    .out_occupancy   (out_occupancy),
    .errors          (errors),
    .pending         (pending),
    .results_seen    (results_seen),
    .full_hits       (full_hits),
    .empty_hits      (empty_hits)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ready = no_idle || ($urandom_range(99) >= 30);
  end

  // issue one request, with a random gap first, and wait for its acceptance
  task automatic send_request(input logic [tpq_pkg::OP_W-1:0] op,
                              input logic [tpq_pkg::TIME_W-1:0] stamp,
                              input logic [tpq_pkg::PROC_W-1:0] proc);
    @(negedge clk);
    if (!no_idle) begin
      while ($urandom_range(99) < 30) begin
        in_valid        = 1'b0;
        in_opcode       = tpq_pkg::OP_W'($urandom());
        in_request_time = tpq_pkg::TIME_W'($urandom());
        in_request_proc = tpq_pkg::PROC_W'($urandom());
        @(negedge clk);
      end
    end
    in_valid        = 1'b1;
    in_opcode       = op;
    in_request_time = stamp;
    in_request_proc = proc;
    op_count[op]++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold the sender until every outstanding result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // timestamps biased towards ties and the extremes
  function automatic logic [tpq_pkg::TIME_W-1:0] pick_stamp();
    int r;
    r = $urandom_range(99);
    if (r < 35) return tpq_pkg::TIME_W'($urandom_range(3));
    if (r < 45) return $urandom_range(1) ? '1 : '0;
    return tpq_pkg::TIME_W'($urandom());
  endfunction

  function automatic logic [tpq_pkg::PROC_W-1:0] pick_proc();
    if ($urandom_range(99) < 30) return tpq_pkg::PROC_W'($urandom_range(1));
    return tpq_pkg::PROC_W'($urandom_range(15));
  endfunction

  // opcode mix pushes the table towards full, empty or neither
  function automatic logic [tpq_pkg::OP_W-1:0] pick_op(mix_t mix);
    int r;
    int enq_pct;
    int deq_pct;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL:  begin enq_pct = 65; deq_pct = 15; end
      MIX_DRAIN: begin enq_pct = 25; deq_pct = 55; end
      default:   begin enq_pct = 42; deq_pct = 35; end
    endcase
    if (r < enq_pct)                return tpq_pkg::OP_ENQ;
    if (r < enq_pct + deq_pct)      return tpq_pkg::OP_DEQ;
    if (r < enq_pct + deq_pct + 15) return tpq_pkg::OP_PEEK;
    return OP_UNUSED;
  endfunction

  // stimulus and verdict
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table: peek, dequeue and an unused opcode
    send_request(tpq_pkg::OP_PEEK, '0, '0);
    send_request(tpq_pkg::OP_DEQ, '1, '1);
    send_request(OP_UNUSED, 16'hA5A5, 4'h5);

    // fill with extremes, timestamp ties and duplicate pairs
    send_request(tpq_pkg::OP_ENQ, 16'h8000, 4'd9);
    send_request(tpq_pkg::OP_ENQ, 16'h8000, 4'd3);
    send_request(tpq_pkg::OP_ENQ, 16'hFFFF, 4'd15);
    send_request(tpq_pkg::OP_ENQ, 16'h0000, 4'd15);
    send_request(tpq_pkg::OP_ENQ, 16'h0000, 4'd0);
    send_request(tpq_pkg::OP_ENQ, 16'h1234, 4'd5);
    send_request(tpq_pkg::OP_ENQ, 16'h1234, 4'd5);
    send_request(tpq_pkg::OP_ENQ, 16'hFFFF, 4'd0);
    send_request(tpq_pkg::OP_ENQ, 16'h0000, 4'd0);
    for (int i = 0; i < tpq_pkg::QUEUE_DEPTH - 9; i++)
      send_request(tpq_pkg::OP_ENQ, tpq_pkg::TIME_W'(16'h4000 + i), tpq_pkg::PROC_W'(i));

    // full table
    send_request(tpq_pkg::OP_ENQ, 16'h0001, 4'd1);
    send_request(OP_UNUSED, 16'h5A5A, 4'hA);
    send_request(tpq_pkg::OP_PEEK, '0, '0);
    send_request(tpq_pkg::OP_DEQ, '0, '0);
    send_request(tpq_pkg::OP_DEQ, '0, '0);
    send_request(tpq_pkg::OP_PEEK, '1, '1);

    wait_drained();

    // random phases, one of them without any idling
    for (int phase = 0; phase < RANDOM_ITEMS / PHASE_LEN; phase++) begin
      no_idle = (phase == 4);
      for (int n = 0; n < PHASE_LEN; n++)
        send_request(pick_op(mix_t'(phase % 3)), pick_stamp(), pick_proc());
      if (phase % 4 == 3)
        wait_drained();
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d requests: %0d enqueue, %0d dequeue, %0d peek, %0d unused opcode",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[tpq_pkg::OP_ENQ], op_count[tpq_pkg::OP_DEQ],
             op_count[tpq_pkg::OP_PEEK], op_count[OP_UNUSED]);
    $display("%0d results checked, %0d full refusals, %0d empty answers",
             results_seen, full_hits, empty_hits);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
src/tpq_pkg.sv
src/tpq_best.sv
src/timestamp_priority_queue.sv
dv/tpq_checker.sv
dv/tb_timestamp_priority_queue.sv
